[rtl/tccp_pkg.sv]
// Package for the terminal cell color packer.
// Holds color kind codes, flag bit positions and quantizer thresholds.
// No dependencies.
package tccp_pkg;

    typedef enum logic [1:0] {
        KIND_DEFAULT = 2'd0,
        KIND_INDEXED = 2'd1,
        KIND_RGB     = 2'd2,
        KIND_UNKNOWN = 2'd3
    } color_kind_t;

    localparam int FLAG_W        = 7;
    localparam int FLAG_BOLD     = 0;
    localparam int FLAG_INVERSE  = 1;
    localparam int FLAG_UNDERLN  = 2;
    localparam int FLAG_DIM      = 3;
    localparam int FLAG_HIDDEN   = 4;
    localparam int FLAG_STRIKE   = 5;
    localparam int FLAG_CONT     = 6;

    localparam logic [20:0] CP_SPACE = 21'h20;

    localparam logic [3:0] FG_DEFAULT = 4'd7;
    localparam logic [3:0] BG_DEFAULT = 4'd0;
    localparam logic [3:0] COLOR_BLACK = 4'd0;
    localparam logic [3:0] COLOR_GREY  = 4'd7;
    localparam logic [3:0] COLOR_DGREY = 4'd8;
    localparam logic [3:0] COLOR_WHITE = 4'd15;

    // RGB quantizer thresholds.
    localparam logic [7:0] DARK_LIMIT   = 8'd64;
    localparam logic [7:0] WHITE_LIMIT  = 8'd190;
    localparam logic [7:0] BRIGHT_LIMIT = 8'd170;
    localparam logic [7:0] CHROMA_LIMIT = 8'd40;
    localparam logic [7:0] CHAN_LIMIT   = 8'd100;

    // Palette index ranges.
    localparam logic [7:0] IDX_CUBE_BASE = 8'd16;
    localparam logic [7:0] IDX_GREY_BASE = 8'd232;
    localparam logic [7:0] IDX_LGREY     = 8'd244;
    localparam logic [7:0] CUBE_OFFSET   = 8'd55;
    localparam logic [7:0] CUBE_STEP     = 8'd40;
    localparam logic [7:0] CUBE_PLANE    = 8'd36;
    localparam logic [7:0] CUBE_ROW      = 8'd6;

    typedef struct packed {
        logic [20:0] codepoint;
        logic [1:0]  width;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic [FLAG_W-1:0] flags;
    } packed_cell_t;

endpackage

[rtl/terminal_cell_color_packer.sv]
// Terminal cell color packer: packs one screen cell into a compact cell per clock when not stalled.
// Depends on tccp_pkg for kind codes, flag positions and thresholds.
//
// One cell is accepted per clock while item_stall is low. The first register
// captures the raw cell at the input transfer, the quantizers for both colors
// run between that register and the result register, and the result register
// loads a valid cell when it is empty or its held result is taken. Each stage
// holds its item while the downstream side stalls, so a stall on the result
// channel reaches the input stall only when both stages are full. Indexed
// colors go through the 16-color pass-through, the grey ramp or the 6x6x6
// cube; RGB colors go through threshold and saturation rules. Continuation
// cells pack to zero with only the continuation flag set.
module terminal_cell_color_packer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic        is_continuation,
    input  logic [20:0] codepoint,
    input  logic [1:0]  cell_width,
    input  logic [1:0]  fg_kind,
    input  logic [23:0] fg_value,
    input  logic [1:0]  bg_kind,
    input  logic [23:0] bg_value,
    input  logic        attr_bold,
    input  logic        attr_reverse,
    input  logic        attr_underline,
    input  logic        attr_conceal,
    input  logic        attr_strike,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [20:0] out_codepoint,
    output logic [1:0]  out_width,
    output logic [3:0]  out_fg,
    output logic [3:0]  out_bg,
    output logic [6:0]  out_flags
);

    function automatic logic [3:0] quant_rgb(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        logic [7:0] mx;
        logic [7:0] mn;
        logic       bright;
        logic [3:0] c;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        bright = (mx > tccp_pkg::BRIGHT_LIMIT);
        c = {bright, (b > tccp_pkg::CHAN_LIMIT), (g > tccp_pkg::CHAN_LIMIT),
             (r > tccp_pkg::CHAN_LIMIT)};
        if (mx < tccp_pkg::DARK_LIMIT)
            return tccp_pkg::COLOR_BLACK;
        else if (mn > tccp_pkg::WHITE_LIMIT)
            return tccp_pkg::COLOR_WHITE;
        else if ((mx - mn) < tccp_pkg::CHROMA_LIMIT)
            return bright ? tccp_pkg::COLOR_GREY : tccp_pkg::COLOR_DGREY;
        else
            return c;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] v);
        logic [7:0] lvl;
        lvl = 8'(tccp_pkg::CUBE_OFFSET + 8'(v) * tccp_pkg::CUBE_STEP);
        return (v == 3'd0) ? 8'd0 : lvl;
    endfunction

    // The cube digits come from comparisons against multiples of 36 and 6,
    // so no divider is needed.
    function automatic logic [3:0] quant_index(input logic [7:0] idx);
        logic [7:0] k;
        logic [2:0] dr;
        logic [2:0] dg;
        logic [7:0] rem_r;
        logic [7:0] rem_g;
        k = idx - tccp_pkg::IDX_CUBE_BASE;
        if      (k >= 8'd180) dr = 3'd5;
        else if (k >= 8'd144) dr = 3'd4;
        else if (k >= 8'd108) dr = 3'd3;
        else if (k >= 8'd72)  dr = 3'd2;
        else if (k >= 8'd36)  dr = 3'd1;
        else                  dr = 3'd0;
        rem_r = k - 8'(8'(dr) * tccp_pkg::CUBE_PLANE);
        if      (rem_r >= 8'd30) dg = 3'd5;
        else if (rem_r >= 8'd24) dg = 3'd4;
        else if (rem_r >= 8'd18) dg = 3'd3;
        else if (rem_r >= 8'd12) dg = 3'd2;
        else if (rem_r >= 8'd6)  dg = 3'd1;
        else                     dg = 3'd0;
        rem_g = rem_r - 8'(8'(dg) * tccp_pkg::CUBE_ROW);
        if (idx < tccp_pkg::IDX_CUBE_BASE)
            return idx[3:0];
        else if (idx >= tccp_pkg::IDX_LGREY)
            return tccp_pkg::COLOR_GREY;
        else if (idx >= tccp_pkg::IDX_GREY_BASE)
            return tccp_pkg::COLOR_DGREY;
        else
            return quant_rgb(cube_level(dr), cube_level(dg), cube_level(rem_g[2:0]));
    endfunction

    function automatic logic [3:0] quant_color(input logic [1:0] kind,
                                               input logic [23:0] value,
                                               input logic [3:0] dflt);
        logic [3:0] res;
        case (tccp_pkg::color_kind_t'(kind))
            tccp_pkg::KIND_INDEXED: res = quant_index(value[7:0]);
            tccp_pkg::KIND_RGB:     res = quant_rgb(value[23:16], value[15:8], value[7:0]);
            default:                res = dflt;
        endcase
        return res;
    endfunction

    // Input register stage.
    logic        a_valid_reg;
    logic        a_cont_reg;
    logic [20:0] a_cp_reg;
    logic [1:0]  a_width_reg;
    logic [1:0]  a_fg_kind_reg;
    logic [23:0] a_fg_value_reg;
    logic [1:0]  a_bg_kind_reg;
    logic [23:0] a_bg_value_reg;
    logic [4:0]  a_attr_reg;

    // Result register stage.
    logic                  b_valid_reg;
    tccp_pkg::packed_cell_t b_cell_reg;
    tccp_pkg::packed_cell_t b_cell_next;

    logic b_load;
    logic a_load;

    assign b_load     = a_valid_reg && (!b_valid_reg || !result_stall);
    assign a_load     = !a_valid_reg || b_load;
    assign item_stall = !a_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_load)
                a_valid_reg <= item_valid;
            if (b_load)
                b_valid_reg <= 1'b1;
            else if (!result_stall)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load && item_valid)
        begin
            a_cont_reg     <= is_continuation;
            a_cp_reg       <= codepoint;
            a_width_reg    <= cell_width;
            a_fg_kind_reg  <= fg_kind;
            a_fg_value_reg <= fg_value;
            a_bg_kind_reg  <= bg_kind;
            a_bg_value_reg <= bg_value;
            a_attr_reg     <= {attr_strike, attr_conceal, attr_underline,
                               attr_reverse, attr_bold};
        end
        if (b_load)
            b_cell_reg <= b_cell_next;
    end

    always_comb
    begin
        b_cell_next = '0;
        if (a_cont_reg)
        begin
            b_cell_next.flags[tccp_pkg::FLAG_CONT] = 1'b1;
        end
        else
        begin
            b_cell_next.codepoint = (a_cp_reg == 21'd0) ? tccp_pkg::CP_SPACE : a_cp_reg;
            case (a_width_reg)
                2'd0:    b_cell_next.width = 2'd1;
                2'd3:    b_cell_next.width = 2'd2;
                default: b_cell_next.width = a_width_reg;
            endcase
            b_cell_next.fg = quant_color(a_fg_kind_reg, a_fg_value_reg, tccp_pkg::FG_DEFAULT);
            b_cell_next.bg = quant_color(a_bg_kind_reg, a_bg_value_reg, tccp_pkg::BG_DEFAULT);
            b_cell_next.flags[tccp_pkg::FLAG_BOLD]    = a_attr_reg[0];
            b_cell_next.flags[tccp_pkg::FLAG_INVERSE] = a_attr_reg[1];
            b_cell_next.flags[tccp_pkg::FLAG_UNDERLN] = a_attr_reg[2];
            b_cell_next.flags[tccp_pkg::FLAG_DIM]     = 1'b0;
            b_cell_next.flags[tccp_pkg::FLAG_HIDDEN]  = a_attr_reg[3];
            b_cell_next.flags[tccp_pkg::FLAG_STRIKE]  = a_attr_reg[4];
        end
    end

    assign result_valid  = b_valid_reg;
    assign out_codepoint = b_cell_reg.codepoint;
    assign out_width     = b_cell_reg.width;
    assign out_fg        = b_cell_reg.fg;
    assign out_bg        = b_cell_reg.bg;
    assign out_flags     = b_cell_reg.flags;

endmodule

[verif/terminal_cell_color_packer_tb.sv]
// Self-checking testbench for terminal_cell_color_packer: directed corner cells,
// then random cells, with random idling on both channels and a scoreboard.
// Depends on tccp_pkg (rtl/tccp_pkg.sv) and the block's RTL.
`timescale 1ns / 100ps

module terminal_cell_color_packer_tb;

    localparam int NUM_RANDOM     = 1425;
    localparam int IDLE_PCT       = 36;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic                  is_continuation;
        logic [20:0]           codepoint;
        logic [1:0]            cell_width;
        tccp_pkg::color_kind_t fg_kind;
        logic [23:0]           fg_value;
        tccp_pkg::color_kind_t bg_kind;
        logic [23:0]           bg_value;
        logic [4:0]            attrs;    // strike, conceal, underline, reverse, bold
    } screen_cell_t;

    class cell_scoreboard;
        tccp_pkg::packed_cell_t expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function logic [3:0] quantize_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic [7:0] hi;
            logic [7:0] lo;
            logic       bright;
            logic [3:0] hue;
            hi = r;
            lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            if (hi < tccp_pkg::DARK_LIMIT) return tccp_pkg::COLOR_BLACK;
            if (lo > tccp_pkg::WHITE_LIMIT) return tccp_pkg::COLOR_WHITE;
            bright = hi > tccp_pkg::BRIGHT_LIMIT;
            if (hi - lo < tccp_pkg::CHROMA_LIMIT)
                return bright ? tccp_pkg::COLOR_GREY : tccp_pkg::COLOR_DGREY;
            hue = {1'b0, b > tccp_pkg::CHAN_LIMIT, g > tccp_pkg::CHAN_LIMIT,
                   r > tccp_pkg::CHAN_LIMIT};
            return bright ? hue + 4'd8 : hue;
        endfunction

        function logic [7:0] cube_level(int step);
            return (step == 0) ? 8'd0 : 8'(55 + step * 40);
        endfunction

        function logic [3:0] quantize_index(logic [7:0] idx);
            int k;
            if (idx < tccp_pkg::IDX_CUBE_BASE) return idx[3:0];
            if (idx >= tccp_pkg::IDX_LGREY) return tccp_pkg::COLOR_GREY;
            if (idx >= tccp_pkg::IDX_GREY_BASE) return tccp_pkg::COLOR_DGREY;
            k = int'(idx) - 16;
            return quantize_rgb(cube_level(k / 36), cube_level((k / 6) % 6),
                                cube_level(k % 6));
        endfunction

        function logic [3:0] quantize_color(tccp_pkg::color_kind_t kind,
                                            logic [23:0] value, bit is_fg);
            case (kind)
                tccp_pkg::KIND_INDEXED: return quantize_index(value[7:0]);
                tccp_pkg::KIND_RGB:
                    return quantize_rgb(value[23:16], value[15:8], value[7:0]);
                default: return is_fg ? tccp_pkg::FG_DEFAULT : tccp_pkg::BG_DEFAULT;
            endcase
        endfunction

        function tccp_pkg::packed_cell_t predict_cell(screen_cell_t c);
            tccp_pkg::packed_cell_t p;
            p = '0;
            if (c.is_continuation)
            begin
                p.flags[tccp_pkg::FLAG_CONT] = 1'b1;
                return p;
            end
            p.codepoint = (c.codepoint == 21'd0) ? tccp_pkg::CP_SPACE : c.codepoint;
            p.width = (c.cell_width == 2'd0) ? 2'd1 :
                      (c.cell_width == 2'd3) ? 2'd2 : c.cell_width;
            p.fg = quantize_color(c.fg_kind, c.fg_value, 1'b1);
            p.bg = quantize_color(c.bg_kind, c.bg_value, 1'b0);
            p.flags[tccp_pkg::FLAG_BOLD]     = c.attrs[0];
            p.flags[tccp_pkg::FLAG_INVERSE]  = c.attrs[1];
            p.flags[tccp_pkg::FLAG_UNDERLN]  = c.attrs[2];
            p.flags[tccp_pkg::FLAG_HIDDEN]   = c.attrs[3];
            p.flags[tccp_pkg::FLAG_STRIKE]   = c.attrs[4];
            return p;
        endfunction

        function void note_cell(screen_cell_t c);
            expected_q = {expected_q, predict_cell(c)};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what,
                     got, want);
            errors++;
        endtask

        task check_packed(tccp_pkg::packed_cell_t got);
            tccp_pkg::packed_cell_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result", got.codepoint, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.codepoint !== want.codepoint)
                report_mismatch("out_codepoint", got.codepoint, want.codepoint);
            if (got.width !== want.width)
                report_mismatch("out_width", got.width, want.width);
            if (got.fg !== want.fg)
                report_mismatch("out_fg", got.fg, want.fg);
            if (got.bg !== want.bg)
                report_mismatch("out_bg", got.bg, want.bg);
            if (got.flags !== want.flags)
                report_mismatch("out_flags", got.flags, want.flags);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        is_continuation = 1'b0;
    logic [20:0] codepoint = '0;
    logic [1:0]  cell_width = '0;
    logic [1:0]  fg_kind = '0;
    logic [23:0] fg_value = '0;
    logic [1:0]  bg_kind = '0;
    logic [23:0] bg_value = '0;
    logic        attr_bold = 1'b0;
    logic        attr_reverse = 1'b0;
    logic        attr_underline = 1'b0;
    logic        attr_conceal = 1'b0;
    logic        attr_strike = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [20:0] out_codepoint;
    logic [1:0]  out_width;
    logic [3:0]  out_fg;
    logic [3:0]  out_bg;
    logic [6:0]  out_flags;

    cell_scoreboard cell_sb = new();
    int idle_pct = IDLE_PCT;
    int stuck_cycles = 0;

    terminal_cell_color_packer u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .is_continuation(is_continuation),
        .codepoint      (codepoint),
        .cell_width     (cell_width),
        .fg_kind        (fg_kind),
        .fg_value       (fg_value),
        .bg_kind        (bg_kind),
        .bg_value       (bg_value),
        .attr_bold      (attr_bold),
        .attr_reverse   (attr_reverse),
        .attr_underline (attr_underline),
        .attr_conceal   (attr_conceal),
        .attr_strike    (attr_strike),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_codepoint  (out_codepoint),
        .out_width      (out_width),
        .out_fg         (out_fg),
        .out_bg         (out_bg),
        .out_flags      (out_flags)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic screen_cell_t make_cell(logic cont, logic [20:0] cp, logic [1:0] w,
                                               tccp_pkg::color_kind_t fk, logic [23:0] fv,
                                               tccp_pkg::color_kind_t bk, logic [23:0] bv,
                                               logic [4:0] attrs);
        screen_cell_t c;
        c.is_continuation = cont;
        c.codepoint       = cp;
        c.cell_width      = w;
        c.fg_kind         = fk;
        c.fg_value        = fv;
        c.bg_kind         = bk;
        c.bg_value        = bv;
        c.attrs           = attrs;
        return c;
    endfunction

    // Channel values cluster around the quantizer thresholds half of the time.
    function automatic logic [7:0] random_channel();
        logic [7:0] edges[10] = '{8'd0, 8'd63, 8'd64, 8'd100, 8'd101, 8'd170,
                                  8'd171, 8'd190, 8'd191, 8'd255};
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return edges[$urandom_range(0, 9)];
    endfunction

    function automatic logic [23:0] random_color_value(tccp_pkg::color_kind_t kind);
        if (kind == tccp_pkg::KIND_RGB && $urandom_range(0, 2) != 0)
            return {random_channel(), random_channel(), random_channel()};
        return 24'($urandom());
    endfunction

    function automatic screen_cell_t random_cell();
        screen_cell_t c;
        c.is_continuation = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 5))
            0:       c.codepoint = 21'd0;
            1:       c.codepoint = 21'($urandom_range(32, 126));
            2:       c.codepoint = 21'h10FFFF;
            default: c.codepoint = 21'($urandom());
        endcase
        c.cell_width = 2'($urandom_range(0, 3));
        c.fg_kind    = tccp_pkg::color_kind_t'($urandom_range(0, 3));
        c.bg_kind    = tccp_pkg::color_kind_t'($urandom_range(0, 3));
        c.fg_value   = random_color_value(c.fg_kind);
        c.bg_value   = random_color_value(c.bg_kind);
        c.attrs      = 5'($urandom_range(0, 31));
        return c;
    endfunction

    task automatic send_cell(screen_cell_t c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        is_continuation <= c.is_continuation;
        codepoint       <= c.codepoint;
        cell_width      <= c.cell_width;
        fg_kind         <= c.fg_kind;
        fg_value        <= c.fg_value;
        bg_kind         <= c.bg_kind;
        bg_value        <= c.bg_value;
        attr_bold       <= c.attrs[0];
        attr_reverse    <= c.attrs[1];
        attr_underline  <= c.attrs[2];
        attr_conceal    <= c.attrs[3];
        attr_strike     <= c.attrs[4];
        item_valid      <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        cell_sb.note_cell(c);
    endtask

    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (cell_sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_cell(make_cell(1'b1, 21'h1FFFFF, 2'd3, tccp_pkg::KIND_RGB, 24'hFFFFFF,
                            tccp_pkg::KIND_INDEXED, 24'hFFFFFF, 5'h1F));
        send_cell(make_cell(1'b0, 21'd0, 2'd0, tccp_pkg::KIND_DEFAULT, 24'hFFFFFF,
                            tccp_pkg::KIND_DEFAULT, 24'hFFFFFF, 5'h00));
        send_cell(make_cell(1'b0, 21'h1FFFFF, 2'd3, tccp_pkg::KIND_UNKNOWN, 24'h123456,
                            tccp_pkg::KIND_UNKNOWN, 24'hABCDEF, 5'h1F));
        send_cell(make_cell(1'b0, 21'h10FFFF, 2'd2, tccp_pkg::KIND_INDEXED, 24'h000000,
                            tccp_pkg::KIND_INDEXED, 24'h00000F, 5'h01));
        send_cell(make_cell(1'b0, 21'h41, 2'd1, tccp_pkg::KIND_INDEXED, 24'hFFFF0F,
                            tccp_pkg::KIND_INDEXED, 24'hABCD10, 5'h02));
        send_cell(make_cell(1'b0, 21'h42, 2'd1, tccp_pkg::KIND_INDEXED, 24'h0000E7,
                            tccp_pkg::KIND_INDEXED, 24'h0000E8, 5'h04));
        send_cell(make_cell(1'b0, 21'h43, 2'd1, tccp_pkg::KIND_INDEXED, 24'h0000F3,
                            tccp_pkg::KIND_INDEXED, 24'h0000F4, 5'h08));
        send_cell(make_cell(1'b0, 21'h44, 2'd1, tccp_pkg::KIND_INDEXED, 24'hFF00FF,
                            tccp_pkg::KIND_INDEXED, 24'h0000C4, 5'h10));
        send_cell(make_cell(1'b0, 21'h45, 2'd1, tccp_pkg::KIND_RGB, 24'h000000,
                            tccp_pkg::KIND_RGB, 24'hFFFFFF, 5'h00));
        send_cell(make_cell(1'b0, 21'h46, 2'd1, tccp_pkg::KIND_RGB, 24'h3F3F3F,
                            tccp_pkg::KIND_RGB, 24'h404040, 5'h00));
        send_cell(make_cell(1'b0, 21'h47, 2'd1, tccp_pkg::KIND_RGB, 24'hBFBFBF,
                            tccp_pkg::KIND_RGB, 24'hBEBEBE, 5'h00));
        send_cell(make_cell(1'b0, 21'h48, 2'd1, tccp_pkg::KIND_RGB, 24'hAAAAAA,
                            tccp_pkg::KIND_RGB, 24'hABABAB, 5'h00));
        send_cell(make_cell(1'b0, 21'h49, 2'd1, tccp_pkg::KIND_RGB, 24'hFF0000,
                            tccp_pkg::KIND_RGB, 24'h650000, 5'h00));
        send_cell(make_cell(1'b0, 21'h4A, 2'd1, tccp_pkg::KIND_RGB, 24'h640000,
                            tccp_pkg::KIND_RGB, 24'h00FF00, 5'h00));
        send_cell(make_cell(1'b0, 21'h4B, 2'd1, tccp_pkg::KIND_RGB, 24'hC8A0A0,
                            tccp_pkg::KIND_RGB, 24'hC8A1A1, 5'h00));
        send_cell(make_cell(1'b0, 21'h4C, 2'd1, tccp_pkg::KIND_RGB, 24'h0000FF,
                            tccp_pkg::KIND_RGB, 24'h3F00BF, 5'h00));
        send_cell(make_cell(1'b0, 21'h4D, 2'd2, tccp_pkg::KIND_RGB, 24'h656565,
                            tccp_pkg::KIND_RGB, 24'hFFBF40, 5'h15));
        send_cell(make_cell(1'b1, 21'd0, 2'd0, tccp_pkg::KIND_DEFAULT, 24'd0,
                            tccp_pkg::KIND_DEFAULT, 24'd0, 5'h00));
        send_cell(make_cell(1'b0, 21'd0, 2'd3, tccp_pkg::KIND_INDEXED, 24'h000010,
                            tccp_pkg::KIND_RGB, 24'hC0C0FF, 5'h0A));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == 300)
                wait_for_drain();
            // A long stretch at full rate on both channels.
            idle_pct = (n >= 700 && n < 1000) ? 0 : IDLE_PCT;
            send_cell(random_cell());
        end
        item_valid <= 1'b0;
        while (cell_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (cell_sb.errors == 0 && cell_sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: check each transfer, then choose the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            cell_sb.check_packed({out_codepoint, out_width, out_fg, out_bg, out_flags});
        result_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

[terminal_cell_color_packer.f]
rtl/tccp_pkg.sv
rtl/terminal_cell_color_packer.sv
verif/terminal_cell_color_packer_tb.sv
